// File: rtl/hiam_pkg.sv
// Shared types, codes and fixed-point constants for the heat index alert monitor.
// No dependencies; every other file of the block imports this package.
package hiam_pkg;

    // Reading status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_BUSY = 2'd1;

    // Configuration register indexes
    localparam logic [2:0] CFG_DARK     = 3'd0;
    localparam logic [2:0] CFG_MIN_TEMP = 3'd1;
    localparam logic [2:0] CFG_CAUTION  = 3'd2;
    localparam logic [2:0] CFG_WARNING  = 3'd3;
    localparam logic [2:0] CFG_DANGER   = 3'd4;

    // Alert tiers
    localparam logic [1:0] TIER_SAFE    = 2'd0;
    localparam logic [1:0] TIER_CAUTION = 2'd1;
    localparam logic [1:0] TIER_WARNING = 2'd2;
    localparam logic [1:0] TIER_DANGER  = 2'd3;

    // Rothfusz coefficients scaled by 2^24
    localparam logic [29:0] K1 = 30'd34376771;
    localparam logic [29:0] K2 = 30'd170176860;
    localparam logic [29:0] K3 = 30'd3770770;
    localparam logic [29:0] K4 = 30'd114720;
    localparam logic [29:0] K5 = 30'd919680;
    localparam logic [29:0] K6 = 30'd20615;
    localparam logic [29:0] K7 = 30'd14308;
    localparam logic [29:0] K8 = 30'd33;

    // Accumulator start value: constant term at scale 2^40
    localparam logic signed [63:0] ACC_INIT = -(64'sd711001637 <<< 16);

    // Reciprocals for the constant divisions by 5 and by 9
    localparam logic [29:0] RECIP5 = 30'd6554;
    localparam logic [29:0] RECIP9 = 30'd7282;

    // 32 degrees F in Q16.16
    localparam int OFFSET_Q16 = 32 * 65536;
    // (index * 9) at and above this saturates the index at 255
    localparam int Y_SAT      = 2304;
    localparam logic [7:0] IDX_MAX = 8'd255;

    // Steps of the heat index sequence, in execution order
    typedef enum logic [4:0] {
        OP_TQ_Q = 5'd0,
        OP_TQ   = 5'd1,
        OP_T2   = 5'd2,
        OP_HH   = 5'd3,
        OP_K1   = 5'd4,
        OP_K2   = 5'd5,
        OP_K3H  = 5'd6,
        OP_K3   = 5'd7,
        OP_K4   = 5'd8,
        OP_K5   = 5'd9,
        OP_K6H  = 5'd10,
        OP_K6   = 5'd11,
        OP_K7H  = 5'd12,
        OP_K7   = 5'd13,
        OP_K8H  = 5'd14,
        OP_K8   = 5'd15,
        OP_HIQ  = 5'd16,
        OP_DIV9 = 5'd17
    } op_t;

    localparam op_t OP_LAST = OP_DIV9;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic mul;
        logic wb;
        logic commit;
        op_t  op;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_calc;
        logic slot_free;
    } dp_status_t;

    // floor(r * 65536 / 5) for a remainder r of a division by 5
    function automatic logic [15:0] frac5(input logic [2:0] r);
        logic [15:0] f;
        case (r)
            3'd1:    f = 16'd13107;
            3'd2:    f = 16'd26214;
            3'd3:    f = 16'd39321;
            3'd4:    f = 16'd52428;
            default: f = 16'd0;
        endcase
        return f;
    endfunction

endpackage

// File: rtl/heat_index_alert_monitor_core.sv
// Heat index alert monitor, top level: ties the controller to the datapath.
// Depends on hiam_pkg, hiam_ctrl and hiam_dp.
//
// One sensor round per input item, one result item per round. A good reading
// at or above formula_min_temp runs the Rothfusz regression in 18 steps on a
// single shared 34x30 multiplier, each step a multiply state and then a
// writeback state. The next item is accepted only after the previous round
// commits. Busy, failed and low-temperature rounds skip the regression and
// go straight to commit. A result waits in the output register
// until taken; the next round is accepted meanwhile but is not committed until
// the slot frees. Configuration writes are taken every cycle.
module heat_index_alert_monitor_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] reading_status,
    input  logic [7:0] temperature,
    input  logic [6:0] humidity,
    input  logic [6:0] light_percent,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] heat_index,
    output logic       reading_valid,
    output logic [1:0] alert_tier,
    output logic [7:0] fail_count,
    output logic       night_mode,
    output logic       mode_changed,
    output logic       buzz_request
);
    import hiam_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    hiam_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    hiam_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .reading_status (reading_status),
        .temperature    (temperature),
        .humidity       (humidity),
        .light_percent  (light_percent),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .heat_index     (heat_index),
        .reading_valid  (reading_valid),
        .alert_tier     (alert_tier),
        .fail_count     (fail_count),
        .night_mode     (night_mode),
        .mode_changed   (mode_changed),
        .buzz_request   (buzz_request)
    );

    // An accepted item blocks the input for at least the next cycle
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

    // A commit always presents a result
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("commit without result");

    // No new item while the sequencer is running
    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mul || cmd.wb) |-> !in_ready)
        else $error("ready during calculation");

    // Before any good reading the heat index, tier and buzz request stay at reset
    a_no_reading: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !reading_valid) |->
            (alert_tier == TIER_SAFE && heat_index == 8'd0 && !buzz_request))
        else $error("held values changed before a good reading");

    // Buzz only in danger, with a valid reading, out of night mode
    a_buzz_cond: assert property (@(posedge clk) disable iff (!rst_n)
        buzz_request |-> (reading_valid && !night_mode && alert_tier == TIER_DANGER))
        else $error("buzz request without its conditions");

endmodule

// File: rtl/hiam_dp.sv
// Datapath: configuration registers, input latch, shared multiplier with
// accumulator for the heat index, and the held monitor state. Uses hiam_pkg.
module hiam_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hiam_pkg::ctrl_cmd_t    cmd,
    output hiam_pkg::dp_status_t   status,
    input  logic [1:0]             reading_status,
    input  logic [7:0]             temperature,
    input  logic [6:0]             humidity,
    input  logic [6:0]             light_percent,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [7:0]             heat_index,
    output logic                   reading_valid,
    output logic [1:0]             alert_tier,
    output logic [7:0]             fail_count,
    output logic                   night_mode,
    output logic                   mode_changed,
    output logic                   buzz_request
);
    import hiam_pkg::*;

    // Configuration
    logic [6:0] dark_reg;
    logic [7:0] min_temp_reg;
    logic [7:0] caution_reg;
    logic [7:0] warning_reg;
    logic [7:0] danger_reg;

    // Latched input item
    logic [1:0] status_reg;
    logic [7:0] t_reg;
    logic [6:0] h_reg;
    logic [6:0] light_reg;

    // Arithmetic registers
    logic [11:0]        m;
    logic [11:0]        q5;
    logic [2:0]         r5;
    logic [8:0]         q_reg;
    logic [24:0]        tq_reg;
    logic [33:0]        t2_reg;
    logic [13:0]        hh_reg;
    logic [28:0]        kh_reg;
    logic [33:0]        mul_a;
    logic [29:0]        mul_b;
    logic [63:0]        mul_p;
    logic [63:0]        prod_reg;
    logic signed [63:0] term;
    logic signed [63:0] acc_reg;
    logic signed [63:0] acc_round;
    logic signed [39:0] hiq_reg;
    logic signed [40:0] diff;
    logic signed [43:0] diff_x5;
    logic [27:0]        y_full;
    logic [11:0]        y_reg;
    logic               neg_reg;
    logic               sat_reg;
    logic [7:0]         idx_reg;

    // Held monitor state
    logic       valid_reg,   valid_next;
    logic [7:0] index_reg,   index_next;
    logic [1:0] tier_reg,    tier_next;
    logic [7:0] fail_reg,    fail_next;
    logic       night_reg,   night_next;
    logic       changed_reg, changed_next;
    logic       buzz_reg,    buzz_next;
    logic       out_valid_reg, out_valid_next;
    logic       reading_ok;

    // Tier lookup; limits tested in caution, warning, danger order
    function automatic logic [1:0] tier_of(input logic [7:0] v);
        if (v < caution_reg)
            return TIER_SAFE;
        if (v < warning_reg)
            return TIER_CAUTION;
        if (v < danger_reg)
            return TIER_WARNING;
        return TIER_DANGER;
    endfunction

    assign cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_reg     <= 7'd5;
            min_temp_reg <= 8'd27;
            caution_reg  <= 8'd27;
            warning_reg  <= 8'd32;
            danger_reg   <= 8'd41;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DARK:     dark_reg     <= cfg_data[6:0];
                CFG_MIN_TEMP: min_temp_reg <= cfg_data;
                CFG_CAUTION:  caution_reg  <= cfg_data;
                CFG_WARNING:  warning_reg  <= cfg_data;
                CFG_DANGER:   danger_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Input latch and status
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg <= reading_status;
            t_reg      <= temperature;
            h_reg      <= humidity;
            light_reg  <= light_percent;
        end
    end

    assign reading_ok       = (status_reg == STATUS_OK);
    assign status.need_calc = reading_ok && (t_reg >= min_temp_reg);
    assign status.slot_free = !out_valid_reg || out_ready;

    // t*9 and its split into quotient and remainder by 5
    assign m  = 12'({t_reg, 3'b000}) + 12'(t_reg);
    assign q5 = 12'({q_reg, 2'b00}) + 12'(q_reg);
    assign r5 = 3'(m - q5);

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_TQ_Q: begin mul_a = 34'(m);      mul_b = RECIP5;         end
            OP_T2:   begin mul_a = 34'(tq_reg); mul_b = 30'(tq_reg);    end
            OP_HH:   begin mul_a = 34'(h_reg);  mul_b = 30'(h_reg);     end
            OP_K1:   begin mul_a = 34'(tq_reg); mul_b = K1;             end
            OP_K2:   begin mul_a = 34'(h_reg);  mul_b = K2;             end
            OP_K3H:  begin mul_a = 34'(h_reg);  mul_b = K3;             end
            OP_K3:   begin mul_a = 34'(tq_reg); mul_b = 30'(kh_reg);    end
            OP_K4:   begin mul_a = t2_reg;      mul_b = K4;             end
            OP_K5:   begin mul_a = 34'(hh_reg); mul_b = K5;             end
            OP_K6H:  begin mul_a = 34'(h_reg);  mul_b = K6;             end
            OP_K6:   begin mul_a = t2_reg;      mul_b = 30'(kh_reg);    end
            OP_K7H:  begin mul_a = 34'(hh_reg); mul_b = K7;             end
            OP_K7:   begin mul_a = 34'(tq_reg); mul_b = 30'(kh_reg);    end
            OP_K8H:  begin mul_a = 34'(hh_reg); mul_b = K8;             end
            OP_K8:   begin mul_a = t2_reg;      mul_b = 30'(kh_reg);    end
            OP_DIV9: begin mul_a = 34'(y_reg);  mul_b = RECIP9;         end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Humidity-only terms carry an extra factor of 2^16
    always_comb
    begin
        case (cmd.op)
            OP_K2, OP_K5: term = signed'({prod_reg[47:0], 16'd0});
            default:      term = signed'(prod_reg);
        endcase
    end

    // Truncate toward zero on the divide by 2^24
    assign acc_round = acc_reg + (acc_reg[63] ? 64'sd16777215 : 64'sd0);

    // Celsius conversion: (hiq - 32F) * 5, then / 65536 here and / 9 later
    assign diff    = {hiq_reg[39], hiq_reg} - 41'(OFFSET_Q16);
    assign diff_x5 = (44'(diff) <<< 2) + 44'(diff);
    assign y_full  = diff_x5[43:16];

    // Multiply phase and writeback phase of each step
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= mul_p;
            if (cmd.op == OP_HIQ)
                hiq_reg <= acc_round[63:24];
        end
        if (cmd.load)
            idx_reg <= temperature;
        if (cmd.wb)
        begin
            case (cmd.op)
                OP_TQ_Q: q_reg <= prod_reg[23:15];
                OP_TQ:
                begin
                    tq_reg  <= {q_reg, 16'd0} + 25'(frac5(r5)) + 25'(OFFSET_Q16);
                    acc_reg <= ACC_INIT;
                end
                OP_T2:   t2_reg <= prod_reg[49:16];
                OP_HH:   hh_reg <= prod_reg[13:0];
                OP_K3H, OP_K6H, OP_K7H, OP_K8H:
                    kh_reg <= prod_reg[28:0];
                OP_K1, OP_K2, OP_K6, OP_K7:
                    acc_reg <= acc_reg + term;
                OP_K3, OP_K4, OP_K5, OP_K8:
                    acc_reg <= acc_reg - term;
                OP_HIQ:
                begin
                    neg_reg <= diff[40] || (diff == 41'sd0);
                    sat_reg <= (y_full >= 28'(Y_SAT));
                    y_reg   <= y_full[11:0];
                end
                OP_DIV9:
                begin
                    if (neg_reg)
                        idx_reg <= 8'd0;
                    else if (sat_reg)
                        idx_reg <= IDX_MAX;
                    else
                        idx_reg <= prod_reg[23:16];
                end
                default: ;
            endcase
        end
    end

    // Next held state for a commit
    always_comb
    begin
        valid_next = valid_reg || reading_ok;
        index_next = reading_ok ? idx_reg : index_reg;
        if (reading_ok)
            fail_next = 8'd0;
        else if (status_reg == STATUS_BUSY || fail_reg == IDX_MAX)
            fail_next = fail_reg;
        else
            fail_next = fail_reg + 8'd1;
        night_next   = (light_reg < dark_reg);
        changed_next = (night_next != night_reg);
        tier_next    = valid_next ? tier_of(index_next) : tier_reg;
        buzz_next    = valid_next && (tier_next == TIER_DANGER) && !night_next;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Held state doubles as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            index_reg     <= 8'd0;
            tier_reg      <= TIER_SAFE;
            fail_reg      <= 8'd0;
            night_reg     <= 1'b0;
            changed_reg   <= 1'b0;
            buzz_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.commit)
            begin
                valid_reg   <= valid_next;
                index_reg   <= index_next;
                tier_reg    <= tier_next;
                fail_reg    <= fail_next;
                night_reg   <= night_next;
                changed_reg <= changed_next;
                buzz_reg    <= buzz_next;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign heat_index    = index_reg;
    assign reading_valid = valid_reg;
    assign alert_tier    = tier_reg;
    assign fail_count    = fail_reg;
    assign night_mode    = night_reg;
    assign mode_changed  = changed_reg;
    assign buzz_request  = buzz_reg;

endmodule

// File: rtl/hiam_ctrl.sv
// Controller: input handshake and the step sequencer that drives the datapath.
// Uses hiam_pkg for the command and status structs and step codes.
module hiam_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  hiam_pkg::dp_status_t  status,
    output hiam_pkg::ctrl_cmd_t   cmd
);
    import hiam_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_MUL    = 5'b00100,
        S_WB     = 5'b01000,
        S_COMMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg,    op_next;

    // Next state and step
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                op_next    = OP_TQ_Q;
                state_next = status.need_calc ? S_MUL : S_COMMIT;
            end
            S_MUL:
                state_next = S_WB;
            S_WB:
            begin
                if (op_reg == OP_LAST)
                    state_next = S_COMMIT;
                else
                begin
                    op_next    = op_t'(op_reg + 5'd1);
                    state_next = S_MUL;
                end
            end
            S_COMMIT:
            begin
                if (status.slot_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_TQ_Q;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // Commands
    assign in_ready   = (state_reg == S_IDLE);
    assign cmd.load   = in_valid && (state_reg == S_IDLE);
    assign cmd.mul    = (state_reg == S_MUL);
    assign cmd.wb     = (state_reg == S_WB);
    assign cmd.commit = (state_reg == S_COMMIT) && status.slot_free;
    assign cmd.op     = op_reg;

endmodule
